// File: design/assert_macros.svh
// assertion macros used by the servo_sweep_range_lock_top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// clocked check, disabled while reset is asserted (active-low reset)
`define SSRL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ssrl assertion failed");
// clocked check with no reset qualification
`define SSRL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("ssrl assertion failed");
`else
`define SSRL_ASSERT(lbl, clk, rst_n, prop)
`define SSRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/ssrl_pkg.sv
// types and constants for the servo sweep range lock block
package ssrl_pkg;

    localparam int ANGLE_W  = 8;
    localparam int DIST_W   = 12;
    localparam int THR_W    = 8;
    localparam int MARGIN_W = 4;
    localparam int NIB_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // saturation ceiling for reported distances
    localparam int DIST_MAX = 4095;

    // reset values
    localparam logic [THR_W-1:0]    THR_RESET      = 8'd30;
    localparam logic [THR_W-1:0]    THR_ZERO_SUB   = 8'd30;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 4'd5;
    localparam logic [ANGLE_W-1:0]  MIN_RESET      = 8'd20;
    localparam logic [ANGLE_W-1:0]  MAX_RESET      = 8'd160;
    localparam logic [NIB_W-1:0]    STEP_RESET     = 4'd2;
    localparam logic [NIB_W-1:0]    INTERVAL_RESET = 4'd3;
    localparam logic [NIB_W-1:0]    MISS_RESET     = 4'd6;
    localparam logic [ANGLE_W-1:0]  ANGLE_RESET    = 8'd90;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEAR_THRESHOLD = 3'd0,
        CFG_RELEASE_MARGIN = 3'd1,
        CFG_MIN_ANGLE      = 3'd2,
        CFG_MAX_ANGLE      = 3'd3,
        CFG_STEP_DEGREES   = 3'd4,
        CFG_MEAS_INTERVAL  = 3'd5,
        CFG_MISS_LIMIT     = 3'd6
    } t_cfg_index;

    // one report beat
    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        logic               sampled;
        logic [DIST_W-1:0]  report_distance;
        logic               meas_valid;
        logic               report_locked;
        logic               lock_alert;
    } t_report;

endpackage

// File: design/ssrl_step_if.sv
// handshake interface carrying one scan step beat
interface ssrl_step_if;
    logic                        valid;
    logic                        ready;
    logic                        range_valid;
    logic [ssrl_pkg::DIST_W-1:0] range_cm;

    modport source (output valid, output range_valid, output range_cm, input ready);
    modport sink   (input valid, input range_valid, input range_cm, output ready);
endinterface

// File: design/ssrl_report_if.sv
// handshake interface carrying one report beat
interface ssrl_report_if;
    logic                         valid;
    logic                         ready;
    logic [ssrl_pkg::ANGLE_W-1:0] servo_angle;
    logic                         sampled;
    logic [ssrl_pkg::DIST_W-1:0]  report_distance;
    logic                         meas_valid;
    logic                         report_locked;
    logic                         lock_alert;

    modport source (output valid, output servo_angle, output sampled,
                    output report_distance, output meas_valid,
                    output report_locked, output lock_alert, input ready);
    modport sink   (input valid, input servo_angle, input sampled,
                    input report_distance, input meas_valid,
                    input report_locked, input lock_alert, output ready);
endinterface

// File: design/servo_sweep_range_lock_top.sv
// servo sweep range lock: scan step in, one report beat out per step
//
// i_step carries one scan step per beat (range_valid, range_cm). o_report
// returns exactly one report per step: servo angle, sample flag, distance,
// valid flag, locked flag and a one-beat lock alert.
// The sweep/lock state is updated in the cycle a step beat is taken and
// the report is loaded into an output register, so a report appears on
// o_report in the cycle after its step beat.
// Throughput is one step per cycle; the only limit is the single output
// register, which frees as soon as its beat is taken.
// When the receiver stalls the report holds and i_step.ready drops only
// while the held report is not being taken.
// Configuration registers are written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must do so only while the block is idle, which the block does not enforce; an unknown index is ignored.
// Synchronous active-low reset restores the register defaults, centers the
// sweep at 90 degrees heading up, drops any lock and empties the output.
`include "assert_macros.svh"

module servo_sweep_range_lock_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ssrl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ssrl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    ssrl_step_if.sink                            i_step,
    ssrl_report_if.source                        o_report
);

    // configuration registers
    logic [ssrl_pkg::THR_W-1:0]    r_near_thr;
    logic [ssrl_pkg::MARGIN_W-1:0] r_margin;
    logic [ssrl_pkg::ANGLE_W-1:0]  r_min_angle;
    logic [ssrl_pkg::ANGLE_W-1:0]  r_max_angle;
    logic [ssrl_pkg::NIB_W-1:0]    r_step_deg;
    logic [ssrl_pkg::NIB_W-1:0]    r_interval;
    logic [ssrl_pkg::NIB_W-1:0]    r_miss_limit;

    // scan state
    logic [ssrl_pkg::ANGLE_W-1:0]  r_sweep_angle, n_sweep_angle;
    logic                          r_sweep_up, n_sweep_up;
    logic                          r_lock_held, n_lock_held;
    logic [ssrl_pkg::ANGLE_W-1:0]  r_held_angle, n_held_angle;
    logic [ssrl_pkg::NIB_W-1:0]    r_step_cnt, n_step_cnt;
    logic [ssrl_pkg::NIB_W-1:0]    r_miss_cnt, n_miss_cnt;
    logic                          r_alert_sent, n_alert_sent;

    // output register
    ssrl_pkg::t_report             r_out, n_out;
    logic                          r_out_valid;

    logic                          step_acc;
    logic [ssrl_pkg::DIST_W-1:0]   dist_sat;
    logic [ssrl_pkg::THR_W-1:0]    thr;
    logic [ssrl_pkg::THR_W:0]      thr_release;
    logic [ssrl_pkg::ANGLE_W:0]    up_sum;
    logic [ssrl_pkg::ANGLE_W:0]    down_floor;
    logic [ssrl_pkg::ANGLE_W-1:0]  adv_angle;
    logic                          adv_up;
    logic [ssrl_pkg::NIB_W-1:0]    step_inc;
    logic [ssrl_pkg::NIB_W-1:0]    miss_inc;
    logic                          near_lock;
    logic                          near_keep;

    assign step_acc     = i_step.valid && i_step.ready;
    assign i_step.ready = !r_out_valid || o_report.ready;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_thr   <= ssrl_pkg::THR_RESET;
            r_margin     <= ssrl_pkg::MARGIN_RESET;
            r_min_angle  <= ssrl_pkg::MIN_RESET;
            r_max_angle  <= ssrl_pkg::MAX_RESET;
            r_step_deg   <= ssrl_pkg::STEP_RESET;
            r_interval   <= ssrl_pkg::INTERVAL_RESET;
            r_miss_limit <= ssrl_pkg::MISS_RESET;
        end else if (i_cfg_we) begin
            case (ssrl_pkg::t_cfg_index'(i_cfg_index))
                ssrl_pkg::CFG_NEAR_THRESHOLD: r_near_thr   <= i_cfg_data;
                ssrl_pkg::CFG_RELEASE_MARGIN: r_margin     <= i_cfg_data[ssrl_pkg::MARGIN_W-1:0];
                ssrl_pkg::CFG_MIN_ANGLE:      r_min_angle  <= i_cfg_data;
                ssrl_pkg::CFG_MAX_ANGLE:      r_max_angle  <= i_cfg_data;
                ssrl_pkg::CFG_STEP_DEGREES:   r_step_deg   <= i_cfg_data[ssrl_pkg::NIB_W-1:0];
                ssrl_pkg::CFG_MEAS_INTERVAL:  r_interval   <= i_cfg_data[ssrl_pkg::NIB_W-1:0];
                ssrl_pkg::CFG_MISS_LIMIT:     r_miss_limit <= i_cfg_data[ssrl_pkg::NIB_W-1:0];
                default: ;
            endcase
        end
    end

    // distance saturation and thresholds
    always_comb begin
        if (32'(i_step.range_cm) > 32'(ssrl_pkg::DIST_MAX)) begin
            dist_sat = ssrl_pkg::DIST_W'(ssrl_pkg::DIST_MAX);
        end else begin
            dist_sat = i_step.range_cm;
        end
        thr         = (r_near_thr == '0) ? ssrl_pkg::THR_ZERO_SUB : r_near_thr;
        thr_release = {1'b0, thr} + {{(ssrl_pkg::THR_W + 1 - ssrl_pkg::MARGIN_W){1'b0}}, r_margin};
        near_lock   = i_step.range_valid &&
                      (dist_sat <= ssrl_pkg::DIST_W'(thr));
        near_keep   = i_step.range_valid &&
                      (dist_sat <= ssrl_pkg::DIST_W'(thr_release));
    end

    // next sweep position, clamped at either end
    always_comb begin
        up_sum     = {1'b0, r_sweep_angle} + {5'd0, r_step_deg};
        down_floor = {1'b0, r_min_angle} + {5'd0, r_step_deg};
        adv_angle  = r_sweep_angle;
        adv_up     = r_sweep_up;
        if (r_sweep_up) begin
            if (up_sum >= {1'b0, r_max_angle}) begin
                adv_angle = r_max_angle;
                adv_up    = 1'b0;
            end else begin
                adv_angle = up_sum[ssrl_pkg::ANGLE_W-1:0];
            end
        end else begin
            if ({1'b0, r_sweep_angle} <= down_floor) begin
                adv_angle = r_min_angle;
                adv_up    = 1'b1;
            end else begin
                adv_angle = r_sweep_angle - {4'd0, r_step_deg};
            end
        end
    end

    // step update and report
    always_comb begin
        n_sweep_angle = r_sweep_angle;
        n_sweep_up    = r_sweep_up;
        n_lock_held   = r_lock_held;
        n_held_angle  = r_held_angle;
        n_step_cnt    = r_step_cnt;
        n_miss_cnt    = r_miss_cnt;
        n_alert_sent  = r_alert_sent;
        step_inc      = r_step_cnt + 4'd1;
        miss_inc      = r_miss_cnt + 4'd1;
        n_out         = '0;

        if (r_lock_held) begin
            n_out.servo_angle   = r_held_angle;
            n_out.sampled       = 1'b1;
            n_out.report_locked = 1'b1;
            if (near_keep) begin
                n_miss_cnt = '0;
            end else if (miss_inc >= r_miss_limit) begin
                // too many misses: drop the lock and sweep on from here
                n_lock_held   = 1'b0;
                n_alert_sent  = 1'b0;
                n_miss_cnt    = '0;
                n_sweep_angle = r_held_angle;
            end else begin
                n_miss_cnt = miss_inc;
            end
        end else begin
            n_out.servo_angle = r_sweep_angle;
            if (step_inc >= r_interval) begin
                n_step_cnt    = '0;
                n_out.sampled = 1'b1;
                if (near_lock) begin
                    n_lock_held         = 1'b1;
                    n_held_angle        = r_sweep_angle;
                    n_miss_cnt          = '0;
                    n_out.report_locked = 1'b1;
                    if (!r_alert_sent) begin
                        n_out.lock_alert = 1'b1;
                        n_alert_sent     = 1'b1;
                    end
                end
            end else begin
                n_step_cnt = step_inc;
            end
            if (!n_out.report_locked) begin
                n_sweep_angle = adv_angle;
                n_sweep_up    = adv_up;
            end
        end

        if (n_out.sampled) begin
            n_out.report_distance = dist_sat;
            n_out.meas_valid      = i_step.range_valid;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_angle <= ssrl_pkg::ANGLE_RESET;
            r_sweep_up    <= 1'b1;
            r_lock_held   <= 1'b0;
            r_held_angle  <= ssrl_pkg::ANGLE_RESET;
            r_step_cnt    <= '0;
            r_miss_cnt    <= '0;
            r_alert_sent  <= 1'b0;
        end else if (step_acc) begin
            r_sweep_angle <= n_sweep_angle;
            r_sweep_up    <= n_sweep_up;
            r_lock_held   <= n_lock_held;
            r_held_angle  <= n_held_angle;
            r_step_cnt    <= n_step_cnt;
            r_miss_cnt    <= n_miss_cnt;
            r_alert_sent  <= n_alert_sent;
        end
    end

    // report output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_report.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_out <= n_out;
        end
    end

    assign o_report.valid           = r_out_valid;
    assign o_report.servo_angle     = r_out.servo_angle;
    assign o_report.sampled         = r_out.sampled;
    assign o_report.report_distance = r_out.report_distance;
    assign o_report.meas_valid      = r_out.meas_valid;
    assign o_report.report_locked   = r_out.report_locked;
    assign o_report.lock_alert      = r_out.lock_alert;

    // checks
    `SSRL_ASSERT(a_alert_only_locked, i_clk, i_rst_n, (r_alert_sent |-> r_lock_held))
    `SSRL_ASSERT(a_locked_step_holds, i_clk, i_rst_n,
        ((step_acc && r_lock_held) |=> (r_out.sampled && r_out.report_locked &&
        (r_out.servo_angle == $past(r_held_angle)))))
    `SSRL_ASSERT(a_alert_implies_lock, i_clk, i_rst_n,
        ((r_out_valid && r_out.lock_alert) |-> (r_out.report_locked && r_lock_held)))

endmodule
